/* rtl/core/gth_pkg.sv */
// Shared constants, types and helpers for the GTH stationary distribution block.
// Depends on nothing; gth_ctrl, gth_datapath and the top import it.
package gth_pkg;

    localparam int MAX_STATES = 16;
    localparam int IDX_W      = $clog2(MAX_STATES);
    localparam int MAT_DEPTH  = MAX_STATES * MAX_STATES;
    localparam int MAT_AW     = $clog2(MAT_DEPTH);
    localparam int WORD_W     = 48;
    localparam int FRAC_W     = 32;

    localparam logic [WORD_W-1:0] WORD_MAX = {WORD_W{1'b1}};
    localparam logic [WORD_W-1:0] ONE_Q32  = WORD_W'(1) << FRAC_W;
    localparam logic [31:0]       ONE_Q31  = 32'h8000_0000;

    typedef enum logic [1:0] {
        WSEL_LOAD  = 2'd0,
        WSEL_DIVQ  = 2'd1,
        WSEL_ACCUM = 2'd2
    } mat_wsel_t;

    typedef struct packed {
        logic [MAT_AW-1:0] mat_addr;
        logic              mat_we;
        mat_wsel_t         mat_wsel;
        logic [IDX_W-1:0]  sol_addr;
        logic              sol_we;
        logic              sol_wsel_one;
        logic              acc_clr;
        logic              acc_add;
        logic              lat_a;
        logic              mul_start;
        logic              mul_x_sol;
        logic              div_start;
        logic              div_out;
        logic              v_load;
        logic              v_add;
        logic              tot_init;
        logic              tot_add;
        logic              out_fire;
        logic              out_err;
        logic              out_last;
        logic [IDX_W-1:0]  out_index;
    } gth_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic sum_zero;
    } gth_status_t;

    function automatic logic [WORD_W-1:0] sat_add(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WORD_W] ? WORD_MAX : s[WORD_W-1:0];
    endfunction

    function automatic logic [MAT_AW-1:0] mat_addr(input logic [IDX_W-1:0] r,
                                                   input logic [IDX_W-1:0] c);
        return MAT_AW'(r) * MAT_AW'(MAX_STATES) + MAT_AW'(c);
    endfunction

endpackage

/* rtl/core/gth_ram.sv */
// Generic single-port RAM with registered read data.
// Depends on nothing.
module gth_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and read one address per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* rtl/core/gth_ctrl.sv */
// Sequencer for load, GTH elimination, back substitution and output.
// Depends on gth_pkg; drives the datapath through gth_cmd_t.
module gth_ctrl
    import gth_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [5:0]       row_index,
    input  logic [5:0]       col_index,
    input  logic             last_entry,
    input  logic [IDX_W-1:0] last_idx,
    input  gth_status_t      status,
    output gth_cmd_t         cmd,
    output logic             busy
);

    typedef enum logic [21:0] {
        ST_IDLE     = 22'h000001,
        ST_SUM_INIT = 22'h000002,
        ST_SUM_RD   = 22'h000004,
        ST_SUM_ACC  = 22'h000008,
        ST_SUM_CHK  = 22'h000010,
        ST_DIV_RD   = 22'h000020,
        ST_DIV_GO   = 22'h000040,
        ST_DIV_WAIT = 22'h000080,
        ST_UPD_RA   = 22'h000100,
        ST_UPD_RB   = 22'h000200,
        ST_UPD_MUL  = 22'h000400,
        ST_UPD_WAIT = 22'h000800,
        ST_BS_INIT  = 22'h001000,
        ST_BS_RD0   = 22'h002000,
        ST_BS_V0    = 22'h004000,
        ST_BS_RDK   = 22'h008000,
        ST_BS_MUL   = 22'h010000,
        ST_BS_MWAIT = 22'h020000,
        ST_BS_WR    = 22'h040000,
        ST_OUT_RD   = 22'h080000,
        ST_OUT_DIV  = 22'h100000,
        ST_OUT_WAIT = 22'h200000
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] n_reg, n_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic             in_range;

    assign busy     = (state_reg != ST_IDLE);
    assign in_range = ({1'b0, row_index} < 7'(MAX_STATES))
                   && ({1'b0, col_index} < 7'(MAX_STATES));

    // hold state and loop counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    // sequence the solve
    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        cmd        = '0;
        cmd.mat_wsel = WSEL_LOAD;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.mat_addr = mat_addr(row_index[IDX_W-1:0], col_index[IDX_W-1:0]);
                if (start)
                begin
                    cmd.mat_we = in_range;
                    if (last_entry)
                    begin
                        n_next = last_idx;
                        state_next = (last_idx == '0) ? ST_BS_INIT : ST_SUM_INIT;
                    end
                end
            end
            ST_SUM_INIT:
            begin
                cmd.acc_clr = 1'b1;
                j_next      = '0;
                state_next  = ST_SUM_RD;
            end
            ST_SUM_RD:
            begin
                cmd.mat_addr = mat_addr(n_reg, j_reg);
                state_next   = ST_SUM_ACC;
            end
            ST_SUM_ACC:
            begin
                cmd.acc_add = 1'b1;
                if (j_reg == n_reg - 1'b1)
                begin
                    state_next = ST_SUM_CHK;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_SUM_RD;
                end
            end
            ST_SUM_CHK:
            begin
                i_next = '0;
                if (status.sum_zero)
                begin
                    cmd.out_fire = 1'b1;
                    cmd.out_err  = 1'b1;
                    cmd.out_last = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DIV_RD;
                end
            end
            ST_DIV_RD:
            begin
                cmd.mat_addr = mat_addr(i_reg, n_reg);
                state_next   = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                cmd.mat_addr = mat_addr(i_reg, n_reg);
                cmd.mat_wsel = WSEL_DIVQ;
                if (status.div_done)
                begin
                    cmd.mat_we = 1'b1;
                    if (i_reg == n_reg - 1'b1)
                    begin
                        i_next     = '0;
                        j_next     = '0;
                        state_next = ST_UPD_RA;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_DIV_RD;
                    end
                end
            end
            ST_UPD_RA:
            begin
                cmd.mat_addr = mat_addr(i_reg, n_reg);
                state_next   = ST_UPD_RB;
            end
            ST_UPD_RB:
            begin
                cmd.lat_a    = 1'b1;
                cmd.mat_addr = mat_addr(n_reg, j_reg);
                state_next   = ST_UPD_MUL;
            end
            ST_UPD_MUL:
            begin
                cmd.mul_start = 1'b1;
                cmd.mat_addr  = mat_addr(i_reg, j_reg);
                state_next    = ST_UPD_WAIT;
            end
            ST_UPD_WAIT:
            begin
                cmd.mat_addr = mat_addr(i_reg, j_reg);
                cmd.mat_wsel = WSEL_ACCUM;
                if (status.mul_done)
                begin
                    cmd.mat_we = 1'b1;
                    state_next = ST_UPD_RA;
                    if (j_reg == n_reg - 1'b1)
                    begin
                        j_next = '0;
                        if (i_reg == n_reg - 1'b1)
                        begin
                            i_next = '0;
                            if (n_reg == IDX_W'(1))
                            begin
                                state_next = ST_BS_INIT;
                            end
                            else
                            begin
                                n_next     = n_reg - 1'b1;
                                state_next = ST_SUM_INIT;
                            end
                        end
                        else
                        begin
                            i_next = i_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
            end
            ST_BS_INIT:
            begin
                cmd.sol_addr     = '0;
                cmd.sol_we       = 1'b1;
                cmd.sol_wsel_one = 1'b1;
                cmd.tot_init     = 1'b1;
                j_next           = IDX_W'(1);
                state_next       = (last_idx == '0) ? ST_OUT_RD : ST_BS_RD0;
                if (last_idx == '0)
                begin
                    j_next = '0;
                end
            end
            ST_BS_RD0:
            begin
                cmd.mat_addr = mat_addr('0, j_reg);
                state_next   = ST_BS_V0;
            end
            ST_BS_V0:
            begin
                cmd.v_load = 1'b1;
                k_next     = IDX_W'(1);
                state_next = (j_reg == IDX_W'(1)) ? ST_BS_WR : ST_BS_RDK;
            end
            ST_BS_RDK:
            begin
                cmd.mat_addr = mat_addr(k_reg, j_reg);
                cmd.sol_addr = k_reg;
                state_next   = ST_BS_MUL;
            end
            ST_BS_MUL:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_x_sol = 1'b1;
                state_next    = ST_BS_MWAIT;
            end
            ST_BS_MWAIT:
            begin
                if (status.mul_done)
                begin
                    cmd.v_add = 1'b1;
                    if (k_reg == j_reg - 1'b1)
                    begin
                        state_next = ST_BS_WR;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_BS_RDK;
                    end
                end
            end
            ST_BS_WR:
            begin
                cmd.sol_addr = j_reg;
                cmd.sol_we   = 1'b1;
                cmd.tot_add  = 1'b1;
                if (j_reg == last_idx)
                begin
                    j_next     = '0;
                    state_next = ST_OUT_RD;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_BS_RD0;
                end
            end
            ST_OUT_RD:
            begin
                cmd.sol_addr = j_reg;
                state_next   = ST_OUT_DIV;
            end
            ST_OUT_DIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_out   = 1'b1;
                state_next    = ST_OUT_WAIT;
            end
            ST_OUT_WAIT:
            begin
                cmd.out_index = j_reg;
                cmd.out_last  = (j_reg == last_idx);
                if (status.div_done)
                begin
                    cmd.out_fire = 1'b1;
                    if (j_reg == last_idx)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/gth_datapath.sv */
// Datapath: matrix and solution RAMs, pivot sum, multi-cycle multiplier,
// bit-serial divider and result registers. Depends on gth_pkg and gth_ram.
module gth_datapath
    import gth_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  gth_cmd_t    cmd,
    input  logic [31:0] transition_prob,
    output gth_status_t status,
    output logic        result_valid,
    output logic [5:0]  state_index,
    output logic [31:0] probability,
    output logic        singular_error,
    output logic        last_result
);

    logic [WORD_W-1:0] mat_wdata, mat_rdata;
    logic [WORD_W-1:0] sol_wdata, sol_rdata;
    logic [WORD_W-1:0] s_reg, a_reg, v_reg, tot_reg;

    // multiplier state
    logic [WORD_W-1:0] mx_reg, my_reg;
    logic [1:0]        mcnt_reg;
    logic              mbusy_reg, mdone_reg, movf_reg;
    logic [WORD_W+2:0] macc_reg;
    logic [31:0]       ma, mb;
    logic [63:0]       pp;
    logic [WORD_W+2:0] addend;
    logic [WORD_W-1:0] mul_res;

    // divider state
    logic [WORD_W-1:0] dr_reg, dd_reg, dsh_reg, dq_reg;
    logic [5:0]        dcnt_reg;
    logic              dbusy_reg, ddone_reg;
    logic [WORD_W-1:0] div_num, div_den;
    logic              div_sat;
    logic [WORD_W:0]   dt;
    logic              dge;
    logic [WORD_W:0]   ddiff;
    logic [WORD_W-1:0] q_half;

    gth_ram #(.WIDTH(WORD_W), .DEPTH(MAT_DEPTH)) u_mat (
        .clk   (clk),
        .we    (cmd.mat_we),
        .addr  (cmd.mat_addr),
        .wdata (mat_wdata),
        .rdata (mat_rdata)
    );

    gth_ram #(.WIDTH(WORD_W), .DEPTH(MAX_STATES)) u_sol (
        .clk   (clk),
        .we    (cmd.sol_we),
        .addr  (cmd.sol_addr),
        .wdata (sol_wdata),
        .rdata (sol_rdata)
    );

    // select matrix write data
    always_comb
    begin
        case (cmd.mat_wsel)
            WSEL_LOAD:  mat_wdata = {{(WORD_W-33){1'b0}}, transition_prob, 1'b0};
            WSEL_DIVQ:  mat_wdata = dq_reg;
            WSEL_ACCUM: mat_wdata = sat_add(mat_rdata, mul_res);
            default:    mat_wdata = '0;
        endcase
    end

    assign sol_wdata = cmd.sol_wsel_one ? ONE_Q32 : v_reg;

    // hold pivot sum, column factor, back-substitution value and total
    always_ff @(posedge clk)
    begin
        if (cmd.acc_clr)
        begin
            s_reg <= '0;
        end
        else if (cmd.acc_add)
        begin
            s_reg <= sat_add(s_reg, mat_rdata);
        end
        if (cmd.lat_a)
        begin
            a_reg <= mat_rdata;
        end
        if (cmd.v_load)
        begin
            v_reg <= mat_rdata;
        end
        else if (cmd.v_add)
        begin
            v_reg <= sat_add(v_reg, mul_res);
        end
        if (cmd.tot_init)
        begin
            tot_reg <= ONE_Q32;
        end
        else if (cmd.tot_add)
        begin
            tot_reg <= sat_add(tot_reg, v_reg);
        end
    end

    assign status.sum_zero = (s_reg == '0);

    // select one 32x32 partial product per cycle
    always_comb
    begin
        case (mcnt_reg)
            2'd0:    begin ma = {16'b0, mx_reg[47:32]}; mb = {16'b0, my_reg[47:32]}; end
            2'd1:    begin ma = {16'b0, mx_reg[47:32]}; mb = my_reg[31:0]; end
            2'd2:    begin ma = mx_reg[31:0]; mb = {16'b0, my_reg[47:32]}; end
            default: begin ma = mx_reg[31:0]; mb = my_reg[31:0]; end
        endcase
        pp = ma * mb;
        case (mcnt_reg)
            2'd0:    addend = (WORD_W+3)'({pp[15:0], 32'b0});
            2'd3:    addend = (WORD_W+3)'(pp[63:32]);
            default: addend = (WORD_W+3)'(pp[47:0]);
        endcase
    end

    assign mul_res = (movf_reg || (macc_reg > (WORD_W+3)'(WORD_MAX)))
                   ? WORD_MAX : macc_reg[WORD_W-1:0];
    assign status.mul_done = mdone_reg;

    // accumulate the four partial products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mbusy_reg <= 1'b0;
            mdone_reg <= 1'b0;
            mcnt_reg  <= '0;
        end
        else
        begin
            mdone_reg <= mbusy_reg && !cmd.mul_start && (mcnt_reg == 2'd3);
            if (cmd.mul_start)
            begin
                mbusy_reg <= 1'b1;
                mcnt_reg  <= '0;
            end
            else if (mbusy_reg)
            begin
                mcnt_reg <= mcnt_reg + 1'b1;
                if (mcnt_reg == 2'd3)
                begin
                    mbusy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_start)
        begin
            mx_reg   <= cmd.mul_x_sol ? sol_rdata : a_reg;
            my_reg   <= mat_rdata;
            macc_reg <= '0;
            movf_reg <= 1'b0;
        end
        else if (mbusy_reg)
        begin
            macc_reg <= macc_reg + addend;
            if (mcnt_reg == 2'd0)
            begin
                movf_reg <= |pp[31:16];
            end
        end
    end

    // restoring division, one quotient bit per cycle
    assign div_num = cmd.div_out ? sol_rdata : mat_rdata;
    assign div_den = cmd.div_out ? tot_reg : s_reg;
    assign div_sat = ({16'b0, div_num} >= {div_den, 16'b0});
    assign dt      = {dr_reg, dsh_reg[WORD_W-1]};
    assign dge     = (dt >= {1'b0, dd_reg});
    assign ddiff   = dt - {1'b0, dd_reg};
    assign status.div_done = ddone_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbusy_reg <= 1'b0;
            ddone_reg <= 1'b0;
            dcnt_reg  <= '0;
        end
        else
        begin
            ddone_reg <= cmd.div_start ? div_sat : (dbusy_reg && (dcnt_reg == '0));
            if (cmd.div_start)
            begin
                dcnt_reg  <= 6'(WORD_W - 1);
                dbusy_reg <= !div_sat;
            end
            else if (dbusy_reg)
            begin
                dcnt_reg <= dcnt_reg - 1'b1;
                if (dcnt_reg == '0)
                begin
                    dbusy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            dd_reg  <= div_den;
            dr_reg  <= {16'b0, div_num[47:16]};
            dsh_reg <= {div_num[15:0], 32'b0};
            dq_reg  <= div_sat ? WORD_MAX : '0;
        end
        else if (dbusy_reg)
        begin
            dr_reg  <= dge ? ddiff[WORD_W-1:0] : dt[WORD_W-1:0];
            dsh_reg <= {dsh_reg[WORD_W-2:0], 1'b0};
            dq_reg  <= {dq_reg[WORD_W-2:0], dge};
        end
    end

    // drive one result per fire, clamped to one
    assign q_half = dq_reg >> 1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid <= 1'b0;
        end
        else
        begin
            result_valid <= cmd.out_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_fire)
        begin
            singular_error <= cmd.out_err;
            last_result    <= cmd.out_last;
            if (cmd.out_err)
            begin
                state_index <= '0;
                probability <= '0;
            end
            else
            begin
                state_index <= 6'(cmd.out_index);
                probability <= (q_half > WORD_W'(ONE_Q31)) ? ONE_Q31 : q_half[31:0];
            end
        end
    end

endmodule

/* rtl/core/gth_stationary_distribution_top.sv */
// GTH stationary distribution solver. A load request is taken while idle; the request
// with last_entry set solves: per pivot n a row sum, one divide per column entry and a
// rank-one update of the leading block; then back substitution and one output divide
// per state. Each result strobes result_valid for one cycle and the receiver cannot
// stall; busy drops as the last result is issued. Reset idles the control and sets
// state_count to 16. Depends on gth_pkg, gth_ctrl, gth_datapath.
module gth_stationary_distribution_top
    import gth_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [5:0]  row_index,
    input  logic [5:0]  col_index,
    input  logic [31:0] transition_prob,
    input  logic        last_entry,
    output logic        result_valid,
    output logic [5:0]  state_index,
    output logic [31:0] probability,
    output logic        singular_error,
    output logic        last_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [2:0] ADDR_STATE_COUNT = 3'd0;

    logic [6:0]       state_count_reg;
    logic [IDX_W-1:0] last_idx;
    gth_cmd_t         cmd;
    gth_status_t      status;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_STATE_COUNT) ? {25'b0, state_count_reg} : 32'b0;

    // write state_count on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_count_reg <= 7'd16;
        end
        else if (psel && penable && pwrite && (paddr == ADDR_STATE_COUNT))
        begin
            state_count_reg <= pwdata[6:0];
        end
    end

    // clamp the dimension to the supported range
    always_comb
    begin
        if (state_count_reg == '0)
        begin
            last_idx = '0;
        end
        else if (state_count_reg > 7'(MAX_STATES))
        begin
            last_idx = IDX_W'(MAX_STATES - 1);
        end
        else
        begin
            last_idx = IDX_W'(state_count_reg - 7'd1);
        end
    end

    gth_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .row_index  (row_index),
        .col_index  (col_index),
        .last_entry (last_entry),
        .last_idx   (last_idx),
        .status     (status),
        .cmd        (cmd),
        .busy       (busy)
    );

    gth_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .transition_prob (transition_prob),
        .status          (status),
        .result_valid    (result_valid),
        .state_index     (state_index),
        .probability     (probability),
        .singular_error  (singular_error),
        .last_result     (last_result)
    );

endmodule
